### design/spq_pkg.sv
// Package for the sorted array priority queue.
// Holds the entry type, the cell control type and the status codes.
`default_nettype none
package spq_pkg;

  typedef struct packed {
    logic signed [31:0] value;
    logic signed [15:0] prio;
  } entry_t;

  typedef struct packed {
    logic push;
    logic pop;
  } cell_ctl_t;

  typedef enum logic [1:0] {
    ST_OK        = 2'd0,
    ST_OVERFLOW  = 2'd1,
    ST_UNDERFLOW = 2'd2
  } status_t;

endpackage
`default_nettype wire

### design/spq_cell.sv
// One slot of the sorted store, with its compare and shift logic.
// Depends on spq_pkg for the entry and control types.
`default_nettype none
module spq_cell (
  input  wire logic              clk,
  input  wire spq_pkg::cell_ctl_t ctl,
  input  wire spq_pkg::entry_t   new_entry,
  input  wire spq_pkg::entry_t   left_entry,
  input  wire logic              left_keep,
  input  wire spq_pkg::entry_t   right_entry,
  input  wire logic              occupied,
  output spq_pkg::entry_t        entry,
  output logic                   keep
);
  import spq_pkg::*;

  entry_t entry_next;

  // The cell holds its entry on a push when it is in use and not strictly lower.
  assign keep = occupied && ($signed(entry.prio) >= $signed(new_entry.prio));

  always_comb begin
    entry_next = entry;
    if (ctl.push) begin
      if (keep) begin
        entry_next = entry;
      end else if (left_keep) begin
        entry_next = new_entry;
      end else begin
        entry_next = left_entry;
      end
    end else if (ctl.pop) begin
      entry_next = right_entry;
    end
  end

  always_ff @(posedge clk) begin
    entry <= entry_next;
  end

endmodule
`default_nettype wire

### design/sorted_array_priority_queue.sv
// Top level of the sorted array priority queue: a row of compare and shift cells.
// Depends on spq_pkg and spq_cell.
// Result: done and the result of a transfer are registered and appear in the cycle after start.
// Throughput: one push or pop every cycle; busy stays low, as each cell compares
// and shifts in the same cycle the item is taken.
// Reset: synchronous, clears the fill count and sets capacity to 16; slots are not cleared.
`default_nettype none
module sorted_array_priority_queue #(
  parameter int DEPTH = 16
) (
  input  wire logic        clk,
  input  wire logic        rst,
  input  wire logic        start,
  output logic             busy,
  input  wire logic        op,
  input  wire logic [31:0] item_value,
  input  wire logic [15:0] item_priority,
  input  wire logic        cfg_we,
  input  wire logic [4:0]  cfg_wdata,
  output logic             done,
  output logic [1:0]       status,
  output logic [31:0]      popped_value,
  output logic [15:0]      popped_priority,
  output logic [4:0]       fill_level
);
  import spq_pkg::*;

  localparam int CW = $clog2(DEPTH + 1);
  localparam int LW = (CW > 5) ? CW : 5;

  logic [CW-1:0] count;
  logic [CW-1:0] count_next;
  logic [4:0]    capacity;
  logic [LW-1:0] limit;
  logic          accept;
  logic          full;
  logic          empty;
  cell_ctl_t     ctl;
  entry_t        new_entry;
  entry_t        cells  [DEPTH];
  logic          keeps  [DEPTH];
  logic          occ    [DEPTH];
  status_t       status_next;

  assign busy   = 1'b0;
  assign accept = start && !busy;
  assign limit  = (LW'(capacity) > LW'(DEPTH)) ? LW'(DEPTH) : LW'(capacity);
  assign full   = LW'(count) >= limit;
  assign empty  = (count == '0);

  assign new_entry.value = item_value;
  assign new_entry.prio  = item_priority;

  assign ctl.push = accept && !op && !full;
  assign ctl.pop  = accept && op && !empty;

  always_comb begin
    count_next  = count;
    status_next = ST_OK;
    if (accept && !op) begin
      if (full) begin
        status_next = ST_OVERFLOW;
      end else begin
        count_next = count + 1'b1;
      end
    end else if (accept && op) begin
      if (empty) begin
        status_next = ST_UNDERFLOW;
      end else begin
        count_next = count - 1'b1;
      end
    end
  end

  for (genvar i = 0; i < DEPTH; i++) begin : g_cell
    assign occ[i] = count > CW'(i);
    spq_cell u_cell (
      .clk         (clk),
      .ctl         (ctl),
      .new_entry   (new_entry),
      .left_entry  ((i == 0) ? new_entry : cells[(i == 0) ? 0 : i - 1]),
      .left_keep   ((i == 0) ? 1'b1 : keeps[(i == 0) ? 0 : i - 1]),
      .right_entry ((i == DEPTH - 1) ? cells[i] : cells[(i == DEPTH - 1) ? i : i + 1]),
      .occupied    (occ[i]),
      .entry       (cells[i]),
      .keep        (keeps[i])
    );
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      count    <= '0;
      capacity <= 5'd16;
      done     <= 1'b0;
    end else begin
      count <= count_next;
      done  <= accept;
      if (cfg_we) begin
        capacity <= cfg_wdata;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (accept) begin
      status     <= status_next;
      fill_level <= 5'(count_next);
      if (ctl.pop) begin
        popped_value    <= cells[0].value;
        popped_priority <= cells[0].prio;
      end else begin
        popped_value    <= '0;
        popped_priority <= '0;
      end
    end
  end

endmodule
`default_nettype wire

### design/spq_checker.sv
// Port level checks for the sorted array priority queue, bound to the top level.
// Depends on spq_pkg for the status codes.
`default_nettype none
module spq_checker (
  input wire logic        clk,
  input wire logic        rst,
  input wire logic        start,
  input wire logic        busy,
  input wire logic        op,
  input wire logic        done,
  input wire logic [1:0]  status,
  input wire logic [31:0] popped_value,
  input wire logic [15:0] popped_priority,
  input wire logic [4:0]  fill_level
);
  import spq_pkg::*;

  a_done_follows: assert property (@(posedge clk) disable iff (rst)
    (start && !busy) |=> done)
    else $error("Accepted transfer gave no result.");

  a_no_spurious: assert property (@(posedge clk) disable iff (rst)
    !(start && !busy) |=> !done)
    else $error("Result without an accepted transfer.");

  a_underflow: assert property (@(posedge clk) disable iff (rst)
    (done && status == ST_UNDERFLOW) |->
      (fill_level == 5'd0 && popped_value == '0 && popped_priority == '0))
    else $error("Underflow result is not empty.");

  a_push_zero: assert property (@(posedge clk) disable iff (rst)
    ($past(start && !busy && !op) && done) |->
      (popped_value == '0 && popped_priority == '0 && status != ST_UNDERFLOW))
    else $error("Push result carries popped data.");

endmodule

bind sorted_array_priority_queue spq_checker u_spq_checker (.*);
`default_nettype wire
